>>> hdl/morse_element_keyer_core_defines.svh
// ----------------------------------------------------------------------------
// Morse element keyer assertion macros
// Shared property macros for the keyer's checks, clocked on clk and
// disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MORSE_ELEMENT_KEYER_CORE_DEFINES_SVH
`define MORSE_ELEMENT_KEYER_CORE_DEFINES_SVH

// Same-cycle implication: whenever cond holds, cons holds as well.
`define MEK_ASSERT_NOW(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: whenever cond holds, cons holds in the following cycle.
`define MEK_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/mek_pkg.sv
// ----------------------------------------------------------------------------
// Morse element keyer package
// Payload types, controller interface structs, constants and the Morse
// pattern table shared by the keyer modules.
// ----------------------------------------------------------------------------
package mek_pkg;

  // Width of the longest key pattern in the table.
  localparam int PAT_W            = 19;
  localparam int DEF_MAX_ELEMENTS = 19;

  localparam logic [1:0] UNITS_ELEM   = 2'd1;
  localparam logic [1:0] UNITS_GAP    = 2'd3;
  localparam logic [3:0] HEX_NIB_MASK = 4'hF;

  // One input transaction.
  typedef struct packed {
    logic [7:0] char_code;
    logic       as_hex;
    logic       message_end;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       key_on;
    logic [1:0] unit_count;
    logic       char_done;
    logic       last_result;
    logic       message_done;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic load_char;
    logic emit_elem;
    logic emit_gap;
  } mek_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pat_done;
    logic second_left;
  } mek_stat_t;

  // Maps a nibble to its ASCII hex digit, upper case letters.
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [3:0] n;
    n = nib & HEX_NIB_MASK;
    if (n < 4'd10) begin
      hex_char = 8'h30 + {4'd0, n};
    end else begin
      hex_char = 8'h41 + {4'd0, n} - 8'd10;
    end
  endfunction

  // Morse key pattern of a character: dot 1, dash 111, space 0, LSB first.
  // Anything other than a digit or a letter gives an empty pattern.
  function automatic logic [PAT_W-1:0] pattern_of(input logic [7:0] c);
    logic [PAT_W-1:0] p;
    case (c)
      8'h30: p = 19'b1110111011101110111;
      8'h31: p = 19'h1DDDD;
      8'h32: p = 19'h07775;
      8'h33: p = 19'h01DD5;
      8'h34: p = 19'h00755;
      8'h35: p = 19'h00155;
      8'h36: p = 19'h00557;
      8'h37: p = 19'h01577;
      8'h38: p = 19'h05777;
      8'h39: p = 19'h17777;
      8'h41, 8'h61: p = 19'b11101;
      8'h42, 8'h62: p = 19'b101010111;
      8'h43, 8'h63: p = 19'h005D7;
      8'h44, 8'h64: p = 19'h00057;
      8'h45, 8'h65: p = 19'h00001;
      8'h46, 8'h66: p = 19'h00175;
      8'h47, 8'h67: p = 19'h00177;
      8'h48, 8'h68: p = 19'h00055;
      8'h49, 8'h69: p = 19'h00005;
      8'h4A, 8'h6A: p = 19'h01DDD;
      8'h4B, 8'h6B: p = 19'h001D7;
      8'h4C, 8'h6C: p = 19'h0015D;
      8'h4D, 8'h6D: p = 19'h00077;
      8'h4E, 8'h6E: p = 19'h00017;
      8'h4F, 8'h6F: p = 19'h00777;
      8'h50, 8'h70: p = 19'h005DD;
      8'h51, 8'h71: p = 19'h01D77;
      8'h52, 8'h72: p = 19'h0005D;
      8'h53, 8'h73: p = 19'h00015;
      8'h54, 8'h74: p = 19'b111;
      8'h55, 8'h75: p = 19'h00075;
      8'h56, 8'h76: p = 19'h001D5;
      8'h57, 8'h77: p = 19'h001DD;
      8'h58, 8'h78: p = 19'h00757;
      8'h59, 8'h79: p = 19'h01DD7;
      8'h5A, 8'h7A: p = 19'h00577;
      default:      p = '0;
    endcase
    pattern_of = p;
  endfunction

endpackage

>>> hdl/morse_element_keyer_core.sv
// ----------------------------------------------------------------------------
// Morse element keyer
// Turns a character, or a byte sent as two hex digits, into Morse key
// elements followed by a three-unit gap per character.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. It then emits
// at most one result per cycle on result, marked by strobe, with no way to
// stall: the receiver must take every strobed result. A character passes a
// load step, one step per key element and one gap step, and in hex mode both
// characters pass them in turn; busy stays high until the final gap is
// emitted. busy falls in the cycle the final result is shown, and the next
// transaction can be taken at the end of that cycle. The element count is set
// by the pattern shift register emptying or reaching MAX_ELEMENTS.

module morse_element_keyer_core #(
  parameter int MAX_ELEMENTS = mek_pkg::DEF_MAX_ELEMENTS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mek_pkg::item_t   item,
  output logic             busy,
  output logic             strobe,
  output mek_pkg::result_t result
);
  import mek_pkg::*;

  mek_cmd_t  cmd;
  mek_stat_t stat;

  // Sequencer.
  mek_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Pattern storage and result registers.
  mek_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .cmd    (cmd),
    .stat   (stat),
    .strobe (strobe),
    .result (result)
  );

endmodule

>>> hdl/mek_dp.sv
// ----------------------------------------------------------------------------
// Morse element keyer datapath
// Holds the captured item, the pattern shift register and the element
// counter, and registers each result with its strobe.
// ----------------------------------------------------------------------------
module mek_dp #(
  parameter int MAX_ELEMENTS = mek_pkg::DEF_MAX_ELEMENTS
) (
  input  logic              clk,
  input  logic              rst,
  input  mek_pkg::item_t    item,
  input  mek_pkg::mek_cmd_t cmd,
  output mek_pkg::mek_stat_t stat,
  output logic              strobe,
  output mek_pkg::result_t  result
);
  import mek_pkg::*;

  localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

  logic [7:0]              code;
  logic                    hex;
  logic                    end_flag;
  logic                    low_sel;
  logic [MAX_ELEMENTS-1:0] pat;
  logic [CNT_W-1:0]        cnt;
  logic [7:0]              cur_char;
  logic                    is_last;

  // Character for the current pass: the byte itself or one of its hex digits.
  always_comb begin
    if (hex) begin
      cur_char = low_sel ? hex_char(code[3:0]) : hex_char(code[7:4]);
    end else begin
      cur_char = code;
    end
  end

  assign stat.pat_done    = (pat == '0) || (cnt == CNT_W'(MAX_ELEMENTS));
  assign stat.second_left = hex && !low_sel;
  assign is_last          = !stat.second_left;

  // Item capture, pattern load and shifting.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code     <= item.char_code;
      hex      <= item.as_hex;
      end_flag <= item.message_end;
      low_sel  <= 1'b0;
    end
    if (cmd.load_char) begin
      pat <= MAX_ELEMENTS'(pattern_of(cur_char));
      cnt <= '0;
    end else if (cmd.emit_elem) begin
      pat <= pat >> 1;
      cnt <= cnt + CNT_W'(1);
    end
    if (cmd.emit_gap) begin
      low_sel <= 1'b1;
    end
  end

  // Result register; the strobe is the only part that needs reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_elem || cmd.emit_gap;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_elem) begin
      result.key_on       <= pat[0];
      result.unit_count   <= UNITS_ELEM;
      result.char_done    <= 1'b0;
      result.last_result  <= 1'b0;
      result.message_done <= 1'b0;
    end else if (cmd.emit_gap) begin
      result.key_on       <= 1'b0;
      result.unit_count   <= UNITS_GAP;
      result.char_done    <= 1'b1;
      result.last_result  <= is_last;
      result.message_done <= is_last && end_flag;
    end
  end

endmodule

>>> hdl/mek_ctrl.sv
// ----------------------------------------------------------------------------
// Morse element keyer controller
// Sequences capture, character load, element and gap emission for each
// input transaction.
// ----------------------------------------------------------------------------
`include "morse_element_keyer_core_defines.svh"

module mek_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  mek_pkg::mek_stat_t stat,
  output mek_pkg::mek_cmd_t  cmd,
  output logic               busy
);
  import mek_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_SEND = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  assign busy = (state != ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_char = 1'b1;
        state_next    = ST_SEND;
      end
      ST_SEND: begin
        if (stat.pat_done) begin
          cmd.emit_gap = 1'b1;
          state_next   = stat.second_left ? ST_LOAD : ST_IDLE;
        end else begin
          cmd.emit_elem = 1'b1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A cycle emits at most one result.
  `MEK_ASSERT_NOW(a_single_emit, cmd.emit_elem, !cmd.emit_gap, "element and gap together")
  // An accepted transaction is followed by a character load.
  `MEK_ASSERT_NEXT(a_start_loads, start && !busy, state == ST_LOAD, "no load after start")
  // The final gap returns the controller to idle.
  `MEK_ASSERT_NEXT(a_gap_idle, cmd.emit_gap && !stat.second_left, !busy, "busy after last gap")

endmodule

>>> dv/tb_morse_element_keyer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Morse element keyer testbench
// Drives characters and hex bytes into the keyer, predicts every key element
// and character gap, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_morse_element_keyer_core;
  import mek_pkg::*;

  localparam int ELEM_LIMIT    = DEF_MAX_ELEMENTS;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int SETTLE_CYCLES = 60;
  localparam int RANDOM_ITEMS  = 170;

  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_SHIFT = 8'h20;

  logic    clk;
  logic    rst;
  logic    start;
  item_t   item;
  logic    busy;
  logic    strobe;
  result_t result;

  // Results still owed by the keyer, oldest first.
  result_t expected_keying[$];
  int      fail_count;

  morse_element_keyer_core DUT (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Key patterns of the digits, dot 1, dash 111, space 0, sent LSB first.
  function automatic logic [18:0] digit_keys(input int d);
    case (d)
      0: return 19'h77777;
      1: return 19'h1DDDD;
      2: return 19'h07775;
      3: return 19'h01DD5;
      4: return 19'h00755;
      5: return 19'h00155;
      6: return 19'h00557;
      7: return 19'h01577;
      8: return 19'h05777;
      default: return 19'h17777;
    endcase
  endfunction

  // Key patterns of the letters, indexed from A.
  function automatic logic [18:0] letter_keys(input int l);
    case (l)
      0: return 19'h0001D;
      1: return 19'h00157;
      2: return 19'h005D7;
      3: return 19'h00057;
      4: return 19'h00001;
      5: return 19'h00175;
      6: return 19'h00177;
      7: return 19'h00055;
      8: return 19'h00005;
      9: return 19'h01DDD;
      10: return 19'h001D7;
      11: return 19'h0015D;
      12: return 19'h00077;
      13: return 19'h00017;
      14: return 19'h00777;
      15: return 19'h005DD;
      16: return 19'h01D77;
      17: return 19'h0005D;
      18: return 19'h00015;
      19: return 19'h00007;
      20: return 19'h00075;
      21: return 19'h001D5;
      22: return 19'h001DD;
      23: return 19'h00757;
      24: return 19'h01DD7;
      default: return 19'h00577;
    endcase
  endfunction

  // Lower case folds onto upper case; anything else has no pattern.
  function automatic logic [18:0] key_pattern(input logic [7:0] c);
    logic [7:0] up;
    up = c;
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      up = c - CASE_SHIFT;
    end
    if (up >= CH_ZERO && up <= CH_NINE) begin
      return digit_keys(int'(up - CH_ZERO));
    end
    if (up >= CH_UPPER_A && up <= CH_UPPER_Z) begin
      return letter_keys(int'(up - CH_UPPER_A));
    end
    return '0;
  endfunction

  // Queues the elements of one character and the gap that closes it.
  task automatic queue_character(input logic [7:0] c);
    logic [18:0] p;
    int          n;
    result_t     r;
    p = key_pattern(c);
    n = 0;
    while (n < ELEM_LIMIT && p != '0) begin
      r = '{key_on: p[0], unit_count: UNITS_ELEM, char_done: 1'b0,
            last_result: 1'b0, message_done: 1'b0};
      expected_keying.push_back(r);
      p = p >> 1;
      n++;
    end
    r = '{key_on: 1'b0, unit_count: UNITS_GAP, char_done: 1'b1,
          last_result: 1'b0, message_done: 1'b0};
    expected_keying.push_back(r);
  endtask

  // Expands one accepted transaction into its keying results.
  task automatic predict_keying(input item_t it);
    logic [3:0] nib;
    result_t    tail;
    if (it.as_hex) begin
      nib = it.char_code[7:4];
      queue_character(nib < 4'd10 ? CH_ZERO + {4'd0, nib}
                                  : CH_UPPER_A + {4'd0, nib} - 8'd10);
      nib = it.char_code[3:0];
      queue_character(nib < 4'd10 ? CH_ZERO + {4'd0, nib}
                                  : CH_UPPER_A + {4'd0, nib} - 8'd10);
    end else begin
      queue_character(it.char_code);
    end
    tail = expected_keying.pop_back();
    tail.last_result  = 1'b1;
    tail.message_done = it.message_end;
    expected_keying.push_back(tail);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Checks strobed results first, then records a newly accepted transaction,
  // so a result and an acceptance on the same edge stay in order.
  always @(posedge clk) begin : check_keying
    result_t want;
    if (!rst) begin
      if (strobe) begin
        if (expected_keying.size() == 0) begin
          $error("result with nothing expected: %p", result);
          fail_count++;
        end else begin
          want = expected_keying.pop_front();
          check_field("key_on", want.key_on, result.key_on);
          check_field("unit_count", want.unit_count, result.unit_count);
          check_field("char_done", want.char_done, result.char_done);
          check_field("last_result", want.last_result, result.last_result);
          check_field("message_done", want.message_done, result.message_done);
        end
      end
      if (start && !busy) begin
        predict_keying(item);
      end
    end
  end

  // Presents one transaction and returns on the edge that accepts it.
  task automatic send_item(input logic [7:0] code, input logic hex, input logic last);
    item_t it;
    it.char_code   = code;
    it.as_hex      = hex;
    it.message_end = last;
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_idle();
    if ($urandom_range(0, 2) == 0) begin
      idle_cycles($urandom_range(1, 6));
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (expected_keying.size() != 0) @(posedge clk);
  endtask

  // Mostly letters and digits in both cases, with some arbitrary bytes.
  function automatic logic [7:0] random_char();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return CH_UPPER_A + 8'($urandom_range(0, 25));
      4, 5:       return CH_LOWER_A + 8'($urandom_range(0, 25));
      6, 7:       return CH_ZERO + 8'($urandom_range(0, 9));
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Table edges, unknown codes next to each range, and hex mode extremes.
  task automatic test_directed();
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    maybe_idle();
    send_item(CH_ZERO, 1'b0, 1'b0);
    send_item(CH_NINE, 1'b0, 1'b0);
    send_item(8'h2F, 1'b0, 1'b0);
    send_item(8'h3A, 1'b0, 1'b0);
    maybe_idle();
    send_item(8'h40, 1'b0, 1'b0);
    send_item(CH_UPPER_A, 1'b0, 1'b0);
    send_item(8'h45, 1'b0, 1'b0);
    send_item(8'h54, 1'b0, 1'b0);
    send_item(CH_UPPER_Z, 1'b0, 1'b0);
    send_item(8'h5B, 1'b0, 1'b1);
    maybe_idle();
    send_item(8'h60, 1'b0, 1'b0);
    send_item(CH_LOWER_A, 1'b0, 1'b0);
    send_item(CH_LOWER_Z, 1'b0, 1'b0);
    send_item(8'h7B, 1'b0, 1'b0);
    send_item(8'h20, 1'b0, 1'b0);
    send_item(8'hC1, 1'b0, 1'b1);
    maybe_idle();
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h9A, 1'b1, 1'b0);
    send_item(8'hA9, 1'b1, 1'b0);
    send_item(8'h0F, 1'b1, 1'b1);
  endtask

  // The sender stops until every owed result is out, then resumes.
  task automatic test_drain_pause();
    repeat (4) send_item(random_char(), 1'b0, 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
    hold_until_drained();
    idle_cycles($urandom_range(1, 6));
    repeat (3) send_item(random_char(), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // Random messages; message_end marks each one's final transaction.
  task automatic test_random_messages();
    int  sent;
    int  len;
    bit  quiet;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      len   = $urandom_range(1, 12);
      quiet = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 4) == 0) begin
          send_item(8'($urandom_range(0, 255)), 1'b1, i == len - 1);
        end else begin
          send_item(random_char(), 1'b0, i == len - 1);
        end
        sent++;
        if (!quiet) begin
          maybe_idle();
        end
      end
    end
  endtask

  // Closing stretch with the sender never pausing.
  task automatic test_back_to_back();
    for (int i = 0; i < 25; i++) begin
      send_item(random_char(), 1'($urandom_range(0, 1)), i == 24);
    end
  endtask

  initial begin : run_tests
    int waited;
    fail_count = 0;
    rst   = 1'b1;
    start = 1'b0;
    item  = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_drain_pause();
    test_random_messages();
    test_back_to_back();

    // Let the last transactions play out, then watch for stray results.
    start <= 1'b0;
    waited = 0;
    while (expected_keying.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_keying.size() != 0) begin
      $error("%0d expected results never arrived", expected_keying.size());
      fail_count += expected_keying.size();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog
    #2000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
